/* hw/rtl/dnfcs_pkg.sv */
// ----------------------------------------------------------------------------
// dnfcs_pkg
// Shared types, codes and the microcode program of the dual NOR flash
// command sequencer.
// ----------------------------------------------------------------------------
package dnfcs_pkg;

    localparam int BYTE_ADDRESS_WIDTH = 19;
    localparam int CHIP_ADDR_WIDTH    = BYTE_ADDRESS_WIDTH - 1;
    localparam int SECTOR_LOW_BITS    = 12;
    localparam int PC_W               = 4;
    localparam int PADDR_W            = 3;

    localparam logic [CHIP_ADDR_WIDTH-1:0] UNLOCK_A = CHIP_ADDR_WIDTH'(32'h5555);
    localparam logic [CHIP_ADDR_WIDTH-1:0] UNLOCK_B = CHIP_ADDR_WIDTH'(32'h2AAA);

    localparam logic [7:0] CMD_UNLOCK_1   = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK_2   = 8'h55;
    localparam logic [7:0] CMD_ERASE_SET  = 8'h80;
    localparam logic [7:0] CMD_PROGRAM    = 8'hA0;
    localparam logic [7:0] CMD_SECTOR     = 8'h30;
    localparam logic [7:0] CMD_CHIP       = 8'h10;

    // operation codes
    localparam logic [1:0] FUNC_READ    = 2'd0;
    localparam logic [1:0] FUNC_PROGRAM = 2'd1;
    localparam logic [1:0] FUNC_SECTOR  = 2'd2;
    localparam logic [1:0] FUNC_CHIP    = 2'd3;

    // wait class codes
    localparam logic [1:0] WC_NONE    = 2'd0;
    localparam logic [1:0] WC_PROGRAM = 2'd1;
    localparam logic [1:0] WC_SECTOR  = 2'd2;
    localparam logic [1:0] WC_CHIP    = 2'd3;

    // register indexes
    localparam logic REG_ENDIAN_SWAP = 1'b0;

    // program entry points
    localparam logic [PC_W-1:0] PC_READ    = 4'd0;
    localparam logic [PC_W-1:0] PC_PROGRAM = 4'd1;
    localparam logic [PC_W-1:0] PC_ERASE   = 4'd5;
    localparam logic [PC_W-1:0] PC_LAST    = 4'd10;

    typedef enum logic [1:0] {
        ADDR_UNLOCK_A = 2'd0,
        ADDR_UNLOCK_B = 2'd1,
        ADDR_CHIP     = 2'd2,
        ADDR_ERASE    = 2'd3
    } t_addr_sel;

    typedef enum logic {
        CHIP_ITEM = 1'b0,
        CHIP_PASS = 1'b1
    } t_chip_sel;

    typedef enum logic [1:0] {
        DATA_CMD   = 2'd0,
        DATA_WRITE = 2'd1,
        DATA_ZERO  = 2'd2,
        DATA_ERASE = 2'd3
    } t_data_sel;

    typedef enum logic [1:0] {
        WAIT_NONE    = 2'd0,
        WAIT_PROGRAM = 2'd1,
        WAIT_ERASE   = 2'd2
    } t_wait_sel;

    typedef enum logic [1:0] {
        FLOW_NEXT = 2'd0,
        FLOW_END  = 2'd1,
        FLOW_LOOP = 2'd2
    } t_flow;

    typedef struct packed {
        t_addr_sel       addr_sel;
        t_chip_sel       chip_sel;
        t_data_sel       data_sel;
        logic [7:0]      cmd;
        logic            is_read;
        t_wait_sel       wait_sel;
        t_flow           flow;
        logic [PC_W-1:0] target;
    } t_uword;

    // one bus cycle handed from the sequencer to the datapath
    typedef struct packed {
        logic   load;
        logic   pass;
        logic   last;
        t_uword uword;
    } t_issue;

    function automatic t_uword uw(input t_addr_sel a, input t_chip_sel c,
                                  input t_data_sel d, input logic [7:0] cmd,
                                  input logic rd, input t_wait_sel w,
                                  input t_flow f, input logic [PC_W-1:0] tgt);
        t_uword r;
        r.addr_sel = a;
        r.chip_sel = c;
        r.data_sel = d;
        r.cmd      = cmd;
        r.is_read  = rd;
        r.wait_sel = w;
        r.flow     = f;
        r.target   = tgt;
        return r;
    endfunction

    // Microcode program. The erase body runs twice: once per chip.
    function automatic t_uword ucode_word(input logic [PC_W-1:0] pc);
        t_uword r;
        case (pc)
            4'd0:    r = uw(ADDR_CHIP, CHIP_ITEM, DATA_ZERO, 8'h00, 1'b1,
                            WAIT_NONE, FLOW_END, PC_READ);
            4'd1:    r = uw(ADDR_UNLOCK_A, CHIP_ITEM, DATA_CMD, CMD_UNLOCK_1, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd2:    r = uw(ADDR_UNLOCK_B, CHIP_ITEM, DATA_CMD, CMD_UNLOCK_2, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd3:    r = uw(ADDR_UNLOCK_A, CHIP_ITEM, DATA_CMD, CMD_PROGRAM, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd4:    r = uw(ADDR_CHIP, CHIP_ITEM, DATA_WRITE, 8'h00, 1'b0,
                            WAIT_PROGRAM, FLOW_END, PC_READ);
            4'd5:    r = uw(ADDR_UNLOCK_A, CHIP_PASS, DATA_CMD, CMD_UNLOCK_1, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd6:    r = uw(ADDR_UNLOCK_B, CHIP_PASS, DATA_CMD, CMD_UNLOCK_2, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd7:    r = uw(ADDR_UNLOCK_A, CHIP_PASS, DATA_CMD, CMD_ERASE_SET, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd8:    r = uw(ADDR_UNLOCK_A, CHIP_PASS, DATA_CMD, CMD_UNLOCK_1, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd9:    r = uw(ADDR_UNLOCK_B, CHIP_PASS, DATA_CMD, CMD_UNLOCK_2, 1'b0,
                            WAIT_NONE, FLOW_NEXT, PC_READ);
            4'd10:   r = uw(ADDR_ERASE, CHIP_PASS, DATA_ERASE, 8'h00, 1'b0,
                            WAIT_ERASE, FLOW_LOOP, PC_ERASE);
            default: r = uw(ADDR_UNLOCK_A, CHIP_ITEM, DATA_ZERO, 8'h00, 1'b0,
                            WAIT_NONE, FLOW_END, PC_READ);
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/dnfcs_sequencer.sv */
// ----------------------------------------------------------------------------
// dnfcs_sequencer
// Step counter and jump logic that walks the microcode program.
// ----------------------------------------------------------------------------
module dnfcs_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_func,
    input  logic                 i_stage_free,
    output logic                 o_busy,
    output dnfcs_pkg::t_issue    o_issue
);
    import dnfcs_pkg::*;

    logic            r_busy, n_busy;
    logic            r_pass, n_pass;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            w_step;
    t_uword          w_uword;

    always_comb begin
        w_uword = ucode_word(r_pc);
        w_step  = r_busy && i_stage_free;
        n_busy  = r_busy;
        n_pass  = r_pass;
        n_pc    = r_pc;
        if (i_accept) begin
            n_busy = 1'b1;
            n_pass = 1'b0;
            case (i_func)
                FUNC_READ:    n_pc = PC_READ;
                FUNC_PROGRAM: n_pc = PC_PROGRAM;
                default:      n_pc = PC_ERASE;
            endcase
        end else if (w_step) begin
            case (w_uword.flow)
                FLOW_NEXT: n_pc = r_pc + PC_W'(1);
                FLOW_LOOP: begin
                    if (!r_pass) begin
                        n_pc   = w_uword.target;
                        n_pass = 1'b1;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                default:   n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pass <= 1'b0;
            r_pc   <= PC_READ;
        end else begin
            r_busy <= n_busy;
            r_pass <= n_pass;
            r_pc   <= n_pc;
        end
    end

    assign o_busy        = r_busy;
    assign o_issue.load  = w_step;
    assign o_issue.pass  = r_pass;
    assign o_issue.last  = (w_uword.flow == FLOW_END) ||
                           ((w_uword.flow == FLOW_LOOP) && r_pass);
    assign o_issue.uword = w_uword;

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= PC_LAST))
        else $error("step counter left the program");

    a_pass_in_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass |-> (r_pc >= PC_ERASE))
        else $error("second pass flag set outside the erase body");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_issue.load && o_issue.last) |=> !r_busy)
        else $error("sequencer kept running after the final cycle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_busy)
        else $error("accepted operation did not start");

endmodule

/* hw/rtl/dnfcs_datapath.sv */
// ----------------------------------------------------------------------------
// dnfcs_datapath
// Operand register and bus-cycle output register driven by the control word.
// ----------------------------------------------------------------------------
module dnfcs_datapath (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_accept,
    input  logic [1:0]                               i_func,
    input  logic [dnfcs_pkg::BYTE_ADDRESS_WIDTH-1:0] i_byte_address,
    input  logic [7:0]                               i_write_data,
    input  logic                                     i_endian_swap,
    input  dnfcs_pkg::t_issue                        i_issue,
    input  logic                                     i_out_ready,
    output logic                                     o_out_valid,
    output logic [dnfcs_pkg::CHIP_ADDR_WIDTH-1:0]    o_chip_address,
    output logic                                     o_select_upper_chip,
    output logic [7:0]                               o_bus_data,
    output logic                                     o_is_read_cycle,
    output logic [1:0]                               o_wait_class,
    output logic                                     o_last_cycle
);
    import dnfcs_pkg::*;

    // held operation
    logic [1:0]                    r_func;
    logic [BYTE_ADDRESS_WIDTH-1:0] r_addr;
    logic [7:0]                    r_data;

    logic                          r_valid;
    logic [CHIP_ADDR_WIDTH-1:0]    r_caddr_out;
    logic                          r_upper;
    logic [7:0]                    r_bus;
    logic                          r_read;
    logic [1:0]                    r_wait;
    logic                          r_last;

    logic [CHIP_ADDR_WIDTH-1:0]    w_caddr;
    logic [CHIP_ADDR_WIDTH-1:0]    w_sector;
    logic                          w_is_sector;
    logic [CHIP_ADDR_WIDTH-1:0]    n_caddr_out;
    logic                          n_upper;
    logic [7:0]                    n_bus;
    logic [1:0]                    n_wait;

    always_comb begin
        w_caddr     = r_addr[BYTE_ADDRESS_WIDTH-1:1];
        w_sector    = {w_caddr[CHIP_ADDR_WIDTH-1:SECTOR_LOW_BITS],
                       {SECTOR_LOW_BITS{1'b0}}};
        w_is_sector = (r_func == FUNC_SECTOR);

        case (i_issue.uword.addr_sel)
            ADDR_UNLOCK_A: n_caddr_out = UNLOCK_A;
            ADDR_UNLOCK_B: n_caddr_out = UNLOCK_B;
            ADDR_CHIP:     n_caddr_out = w_caddr;
            default:       n_caddr_out = w_is_sector ? w_sector : UNLOCK_A;
        endcase

        // erase pass 0 goes to the lower chip select, pass 1 to the upper, reversed when endian_swap is set
        case (i_issue.uword.chip_sel)
            CHIP_ITEM: n_upper = r_addr[0] ^ i_endian_swap;
            default:   n_upper = i_issue.pass ^ i_endian_swap;
        endcase

        case (i_issue.uword.data_sel)
            DATA_CMD:   n_bus = i_issue.uword.cmd;
            DATA_WRITE: n_bus = r_data;
            DATA_ZERO:  n_bus = 8'h00;
            default:    n_bus = w_is_sector ? CMD_SECTOR : CMD_CHIP;
        endcase

        n_wait = WC_NONE;
        if (i_issue.last) begin
            case (i_issue.uword.wait_sel)
                WAIT_PROGRAM: n_wait = WC_PROGRAM;
                WAIT_ERASE:   n_wait = w_is_sector ? WC_SECTOR : WC_CHIP;
                default:      n_wait = WC_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_func <= i_func;
            r_addr <= i_byte_address;
            r_data <= i_write_data;
        end
        if (i_issue.load) begin
            r_caddr_out <= n_caddr_out;
            r_upper     <= n_upper;
            r_bus       <= n_bus;
            r_read      <= i_issue.uword.is_read;
            r_wait      <= n_wait;
            r_last      <= i_issue.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_issue.load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid         = r_valid;
    assign o_chip_address      = r_caddr_out;
    assign o_select_upper_chip = r_upper;
    assign o_bus_data          = r_bus;
    assign o_is_read_cycle     = r_read;
    assign o_wait_class        = r_wait;
    assign o_last_cycle        = r_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |-> !i_issue.load)
        else $error("pending bus cycle overwritten");

    a_wait_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_wait == WC_NONE))
        else $error("wait class on a non-final cycle");

    a_read_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_read) |-> (r_last && (r_bus == 8'h00)))
        else $error("read cycle not final or drives data");

endmodule

/* hw/rtl/dual_nor_flash_command_sequencer.sv */
// ----------------------------------------------------------------------------
// dual_nor_flash_command_sequencer
// Turns flash operations into bus cycles for two byte-interleaved NOR chips.
// ----------------------------------------------------------------------------
// One operation is taken per transfer on the input channel (func, byte
// address, write data) and expanded into its JEDEC bus cycles, each given as
// one result transfer: a read gives one transfer, a byte program four (unlock
// AA/55/A0 to the addressed chip, then the data write), and a sector or
// chip erase twelve (the erase sequence to the lower chip select, then to
// the upper, reversed by endian_swap). Byte address bit 0 XOR endian_swap
// picks the chip; the remaining bits are the chip address, and a sector erase
// clears its low 12 bits. The final cycle carries last_cycle and the wait
// class the host must honour before the next operation. A microcoded
// sequencer steps one control word per clock through a small program table
// while the output register is empty or draining, and holds while the
// output side stalls; a new operation is taken only once the last cycle of
// the previous one has gone into the output register. endian_swap sits at
// byte address 0 of the APB-style port and should be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module dual_nor_flash_command_sequencer (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // operation input
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [1:0]                               i_func,
    input  logic [dnfcs_pkg::BYTE_ADDRESS_WIDTH-1:0] i_byte_address,
    input  logic [7:0]                               i_write_data,
    // bus cycle output
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [dnfcs_pkg::CHIP_ADDR_WIDTH-1:0]    o_chip_address,
    output logic                                     o_select_upper_chip,
    output logic [7:0]                               o_bus_data,
    output logic                                     o_is_read_cycle,
    output logic [1:0]                               o_wait_class,
    output logic                                     o_last_cycle,
    // configuration port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [dnfcs_pkg::PADDR_W-1:0]            paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import dnfcs_pkg::*;

    logic   r_endian_swap;
    logic   w_busy;
    logic   w_accept;
    logic   w_stage_free;
    logic   w_reg_hit;
    t_issue w_issue;

    // word index of the register file is paddr[2]
    assign w_reg_hit    = (paddr[PADDR_W-1] == REG_ENDIAN_SWAP);
    assign pready       = 1'b1;
    assign prdata       = w_reg_hit ? {31'b0, r_endian_swap} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_endian_swap <= 1'b0;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_endian_swap <= pwdata[0];
        end
    end

    // take a new operation only between operations
    assign o_in_ready   = !w_busy;
    assign w_accept     = i_in_valid && !w_busy;
    // advance a step whenever the output register is empty or draining
    assign w_stage_free = !o_out_valid || i_out_ready;

    dnfcs_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_func       (i_func),
        .i_stage_free (w_stage_free),
        .o_busy       (w_busy),
        .o_issue      (w_issue)
    );

    dnfcs_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (w_accept),
        .i_func              (i_func),
        .i_byte_address      (i_byte_address),
        .i_write_data        (i_write_data),
        .i_endian_swap       (r_endian_swap),
        .i_issue             (w_issue),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_chip_address      (o_chip_address),
        .o_select_upper_chip (o_select_upper_chip),
        .o_bus_data          (o_bus_data),
        .o_is_read_cycle     (o_is_read_cycle),
        .o_wait_class        (o_wait_class),
        .o_last_cycle        (o_last_cycle)
    );

endmodule
